[hdl/sha1_pkg.sv]
// sha1 engine package: controller/datapath command and status types,
// initial hash values, round constants and field codes
// no dependencies
`default_nettype none

package sha1_pkg;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// byte source for a block push
	localparam logic [1:0] BSEL_DATA = 2'd0;
	localparam logic [1:0] BSEL_MARK = 2'd1;
	localparam logic [1:0] BSEL_ZERO = 2'd2;
	localparam logic [1:0] BSEL_LEN  = 2'd3;

	localparam logic [7:0] PAD_MARKER = 8'h80;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] FILL_LEN   = 6'd56;
	localparam logic [2:0] WORD_LAST  = 3'd4;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef struct packed {
		logic       push;
		logic [1:0] bsel;
		logic       cnt_len;
		logic       rnd;
		logic [1:0] kph;
		logic       add;
		logic       capture;
		logic       clear;
		logic [2:0] widx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       ovf;
	} dp_sts_t;

	function automatic logic [31:0] round_k(input logic [1:0] ph);
		logic [31:0] k;
		case (ph)
			2'd0:    k = 32'h5A827999;
			2'd1:    k = 32'h6ED9EBA1;
			2'd2:    k = 32'h8F1BBCDC;
			default: k = 32'hCA62C1D6;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[hdl/sha1_if.sv]
// valid/ready channel interfaces for the sha1 engine: message bytes in,
// digest words out
// depends on sha1_pkg
`default_nettype none

interface sha1_msg_if import sha1_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha1_dgst_if import sha1_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  word_index;
	logic [31:0] digest_word;
	logic        last_word;
	logic        too_long;

	modport source (output valid, output word_index, output digest_word,
		output last_word, output too_long, input ready);
	modport sink (input valid, input word_index, input digest_word,
		input last_word, input too_long, output ready);
endinterface

`default_nettype wire

[hdl/sha1_dp.sv]
// sha1 datapath: block shift register with rolling schedule, length count,
// hash and working registers, one round per step, digest output register
// depends on sha1_pkg
`default_nettype none

module sha1_dp import sha1_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	input  wire logic [7:0]  data_byte,
	output dp_sts_t          sts,
	output logic [31:0]      digest_word,
	output logic             too_long
);

	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic         ovf_q;
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  dig_q [5];
	logic         tl_q;

	logic [7:0]   push_byte;
	logic [64:0]  len_nxt;
	logic [31:0]  w0, wnew, f, tmp;
	logic [31:0]  sum [5];

	always_comb begin
		case (cmd.bsel)
			BSEL_DATA: push_byte = data_byte;
			BSEL_MARK: push_byte = PAD_MARKER;
			BSEL_LEN:  push_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
			default:   push_byte = 8'h00;
		endcase
	end

	assign len_nxt = {1'b0, len_q} + 65'd8;

	// schedule taps, word i of the window at [511-32i -: 32]
	assign w0   = blk_q[511:480];
	assign wnew = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ w0;

	always_comb begin
		case (cmd.kph)
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd2:    f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + w0 + round_k(cmd.kph);
	end

	assign sum[0] = h_q[0] + a_q;
	assign sum[1] = h_q[1] + b_q;
	assign sum[2] = h_q[2] + c_q;
	assign sum[3] = h_q[3] + d_q;
	assign sum[4] = h_q[4] + e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			tl_q   <= 1'b0;
			for (int i = 0; i < 5; i++) h_q[i] <= H_INIT[i];
			a_q <= H_INIT[0];
			b_q <= H_INIT[1];
			c_q <= H_INIT[2];
			d_q <= H_INIT[3];
			e_q <= H_INIT[4];
		end else begin
			if (cmd.capture) begin
				tl_q <= ovf_q;
			end
			if (cmd.clear) begin
				fill_q <= '0;
				len_q  <= '0;
				ovf_q  <= 1'b0;
				for (int i = 0; i < 5; i++) h_q[i] <= H_INIT[i];
				a_q <= H_INIT[0];
				b_q <= H_INIT[1];
				c_q <= H_INIT[2];
				d_q <= H_INIT[3];
				e_q <= H_INIT[4];
			end else begin
				if (cmd.push) begin
					fill_q <= fill_q + 6'd1;
				end
				if (cmd.cnt_len) begin
					len_q <= len_nxt[63:0];
					if (len_nxt[64]) begin
						ovf_q <= 1'b1;
					end
				end
				if (cmd.add) begin
					for (int i = 0; i < 5; i++) h_q[i] <= sum[i];
					a_q <= sum[0];
					b_q <= sum[1];
					c_q <= sum[2];
					d_q <= sum[3];
					e_q <= sum[4];
				end else if (cmd.rnd) begin
					a_q <= tmp;
					b_q <= a_q;
					c_q <= {b_q[1:0], b_q[31:2]};
					d_q <= c_q;
					e_q <= d_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q <= {blk_q[503:0], push_byte};
		end else if (cmd.rnd) begin
			blk_q <= {blk_q[479:0], wnew[30:0], wnew[31]};
		end
		if (cmd.capture) begin
			for (int i = 0; i < 5; i++) dig_q[i] <= ovf_q ? 32'h0 : h_q[i];
		end
	end

	always_comb begin
		case (cmd.widx)
			3'd0:    digest_word = dig_q[0];
			3'd1:    digest_word = dig_q[1];
			3'd2:    digest_word = dig_q[2];
			3'd3:    digest_word = dig_q[3];
			3'd4:    digest_word = dig_q[4];
			default: digest_word = 32'h0;
		endcase
	end

	assign too_long = tl_q;
	assign sts.fill = fill_q;
	assign sts.ovf  = ovf_q;

endmodule

`default_nettype wire

[hdl/sha1_ctrl.sv]
// sha1 controller: byte intake, padding sequencer, round counter and
// digest word emitter
// depends on sha1_pkg
`default_nettype none

module sha1_ctrl import sha1_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_cmd,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [4:0] RCNT_LAST  = 5'd19;
	localparam logic [1:0] PHASE_LAST = 2'd3;

	logic [2:0] state_q;
	logic [4:0] rcnt_q;
	logic [1:0] phase_q;
	logic       fin_q, mark_q, lenblk_q;
	logic       emit_busy_q;
	logic [2:0] emit_cnt_q;
	logic       acc, full;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign out_valid = emit_busy_q;
	assign full      = cmd.push && (sts.fill == FILL_LAST);

	always_comb begin
		cmd      = '0;
		cmd.kph  = phase_q;
		cmd.widx = emit_cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && in_cmd == CMD_APPEND && !sts.ovf) begin
					cmd.push    = 1'b1;
					cmd.bsel    = BSEL_DATA;
					cmd.cnt_len = 1'b1;
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (!mark_q) begin
					cmd.bsel = BSEL_MARK;
				end else if (sts.fill < FILL_LEN) begin
					cmd.bsel = BSEL_ZERO;
				end else if (lenblk_q) begin
					cmd.bsel = BSEL_LEN;
				end else begin
					cmd.bsel = BSEL_ZERO;
				end
			end
			ST_ROUND: cmd.rnd = 1'b1;
			ST_ADD:   cmd.add = 1'b1;
			ST_DONE: begin
				if (!emit_busy_q) begin
					cmd.capture = 1'b1;
					cmd.clear   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rcnt_q      <= '0;
			phase_q     <= '0;
			fin_q       <= 1'b0;
			mark_q      <= 1'b0;
			lenblk_q    <= 1'b0;
			emit_busy_q <= 1'b0;
			emit_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (in_cmd == CMD_FINISH) begin
							fin_q   <= 1'b1;
							mark_q  <= 1'b0;
							state_q <= sts.ovf ? ST_DONE : ST_PAD;
						end else if (full) begin
							rcnt_q  <= '0;
							phase_q <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_PAD: begin
					if (!mark_q) begin
						mark_q   <= 1'b1;
						lenblk_q <= (sts.fill < FILL_LEN);
					end
					if (full) begin
						rcnt_q  <= '0;
						phase_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (rcnt_q == RCNT_LAST) begin
						rcnt_q <= '0;
						if (phase_q == PHASE_LAST) begin
							state_q <= ST_ADD;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end else begin
						rcnt_q <= rcnt_q + 5'd1;
					end
				end
				ST_ADD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (lenblk_q) begin
						state_q <= ST_DONE;
					end else begin
						lenblk_q <= 1'b1;
						state_q  <= ST_PAD;
					end
				end
				ST_DONE: begin
					if (!emit_busy_q) begin
						fin_q       <= 1'b0;
						emit_busy_q <= 1'b1;
						emit_cnt_q  <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit_busy_q && out_ready) begin
				if (emit_cnt_q == WORD_LAST) begin
					emit_busy_q <= 1'b0;
				end else begin
					emit_cnt_q <= emit_cnt_q + 3'd1;
				end
			end
		end
	end

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit_busy_q |-> emit_cnt_q <= WORD_LAST)
		else $error("digest word index out of range");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(emit_busy_q) |-> $past(emit_cnt_q) == WORD_LAST)
		else $error("digest emission ended early");

	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !emit_busy_q)
		else $error("digest captured over a pending transfer");

	a_push_or_round: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && (cmd.rnd || cmd.add)))
		else $error("block push during compression");

	a_round_after_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> state_q == ST_ROUND && sts.fill == 6'd0)
		else $error("full block did not start compression");

endmodule

`default_nettype wire

[hdl/sha1_hash_engine.sv]
// sha1_hash_engine: byte-stream sha-1 engine, top level
// ties the controller and datapath to the message and digest channels
// depends on sha1_pkg, sha1_if, sha1_ctrl, sha1_dp
//
// usage:
//   msg carries one item per transfer: cmd append with data_byte, or cmd finish.
//   digest returns five transfers per finish, word_index 0..4 (H0 first),
//   last_word on the fifth, too_long with zero words if the bit length overflowed.
// timing:
//   the append that fills a 64-byte block holds msg.ready low for the 80
//   rounds in the shared round unit plus the hash add.
//   a finish pads one byte per cycle up to the block end, then runs one or
//   two compressions; digest valid rises once the done state has captured
//   the words.
//   the digest drains from its own register, so the next message is accepted
//   while words wait; a later finish waits for the previous digest to drain.
// reset:
//   arst_n restores the initial hash, an empty block and a zero length.
`default_nettype none

module sha1_hash_engine import sha1_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sha1_msg_if.sink     msg,
	sha1_dgst_if.source  digest
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	sha1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_cmd    (msg.cmd),
		.in_ready  (msg.ready),
		.out_valid (digest.valid),
		.out_ready (digest.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.sts         (sts),
		.digest_word (digest.digest_word),
		.too_long    (digest.too_long)
	);

	assign digest.word_index = cmd.widx;
	assign digest.last_word  = (cmd.widx == WORD_LAST);

endmodule

`default_nettype wire

[tb/sha1_hash_engine_tb.sv]
// self-checking testbench for sha1_hash_engine: byte and finish items in, digest words out
// predicts every digest word with its own sha-1 model and checks each transfer in order
// depends on sha1_pkg, sha1_if and the sha1_hash_engine rtl
`timescale 1ns / 100ps

module sha1_hash_engine_tb import sha1_pkg::*; ();

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} msg_item_t;

	typedef struct packed {
		logic [2:0]  word_index;
		logic [31:0] digest_word;
		logic        last_word;
		logic        too_long;
	} dgst_word_t;

	localparam int LIMIT_NS     = 3_000_000;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [31:0] ROUND_CONST [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	logic clk;
	logic arst_n;

	sha1_msg_if  msg_ch ();
	sha1_dgst_if dgst_ch ();

	sha1_hash_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dgst_ch)
	);

	msg_item_t   msg_q[$];
	dgst_word_t  digest_q[$];

	// running hash state of the message in progress
	logic [31:0] hash_st[5];
	logic [7:0]  block_st[64];
	int unsigned fill_st;
	logic [63:0] bits_st;
	logic        ovf_st;

	int   errors;
	int   gap_pct;
	int   stall_pct;
	logic msg_took;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void sha1_compress();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, e, f, wt, tmp;
		for (int t = 0; t < 16; t++)
			w[t] = {block_st[4*t], block_st[4*t+1], block_st[4*t+2], block_st[4*t+3]};
		a = hash_st[0];
		b = hash_st[1];
		c = hash_st[2];
		d = hash_st[3];
		e = hash_st[4];
		for (int t = 0; t < 80; t++) begin
			if (t < 16) begin
				wt = w[t];
			end else begin
				wt = rotl(w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15], 1);
				w[t & 15] = wt;
			end
			if (t < 20)
				f = (b & c) | (~b & d);
			else if (t < 40 || t >= 60)
				f = b ^ c ^ d;
			else
				f = (b & c) | (b & d) | (c & d);
			tmp = rotl(a, 5) + f + e + wt + ROUND_CONST[t / 20];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = tmp;
		end
		hash_st[0] += a;
		hash_st[1] += b;
		hash_st[2] += c;
		hash_st[3] += d;
		hash_st[4] += e;
		fill_st = 0;
	endfunction

	function automatic void clear_msg_state();
		for (int i = 0; i < 5; i++)
			hash_st[i] = H_INIT[i];
		fill_st = 0;
		bits_st = '0;
		ovf_st  = 1'b0;
	endfunction

	function automatic void absorb_item(input msg_item_t it);
		dgst_word_t w;
		if (it.cmd == CMD_APPEND) begin
			if (!ovf_st) begin
				block_st[fill_st] = it.data_byte;
				fill_st++;
				bits_st += 64'd8;
				if (bits_st == 64'd0)
					ovf_st = 1'b1;
				if (fill_st == 64)
					sha1_compress();
			end
		end else begin
			if (!ovf_st) begin
				block_st[fill_st] = PAD_MARKER;
				fill_st++;
				if (fill_st > 56) begin
					while (fill_st < 64) begin
						block_st[fill_st] = 8'h00;
						fill_st++;
					end
					sha1_compress();
				end
				while (fill_st < 56) begin
					block_st[fill_st] = 8'h00;
					fill_st++;
				end
				for (int i = 0; i < 8; i++)
					block_st[56+i] = bits_st[63-8*i -: 8];
				sha1_compress();
			end
			for (int k = 0; k < 5; k++) begin
				w.word_index  = 3'(k);
				w.digest_word = ovf_st ? 32'h0 : hash_st[k];
				w.last_word   = (3'(k) == WORD_LAST);
				w.too_long    = ovf_st;
				digest_q.insert(digest_q.size(), w);
			end
			clear_msg_state();
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endfunction

	function automatic void queue_byte(input logic [7:0] b);
		msg_item_t it;
		it.cmd       = CMD_APPEND;
		it.data_byte = b;
		msg_q.insert(msg_q.size(), it);
	endfunction

	function automatic void queue_finish(input logic [7:0] junk);
		msg_item_t it;
		it.cmd       = CMD_FINISH;
		it.data_byte = junk;
		msg_q.insert(msg_q.size(), it);
	endfunction

	function automatic void queue_random_message(input int len);
		for (int i = 0; i < len; i++)
			queue_byte(8'($urandom_range(0, 255)));
		queue_finish(8'($urandom_range(0, 255)));
	endfunction

	// mostly short messages, with padding boundaries hit often
	function automatic int pick_length();
		int edges[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 6);
			1: return edges[$urandom_range(0, 7)];
			2: return $urandom_range(0, 130);
			default: return $urandom_range(7, 40);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n            = 1'b0;
		msg_ch.valid      = 1'b0;
		msg_ch.cmd        = CMD_APPEND;
		msg_ch.data_byte  = 8'h00;
		dgst_ch.ready     = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// driver: new item once the previous one transferred
	always @(negedge clk) begin
		msg_item_t it;
		if (!arst_n) begin
			msg_ch.valid  <= 1'b0;
			dgst_ch.ready <= 1'b0;
		end else begin
			if (!msg_ch.valid || msg_took) begin
				if (msg_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					it = msg_q.pop_front();
					msg_ch.valid     <= 1'b1;
					msg_ch.cmd       <= it.cmd;
					msg_ch.data_byte <= it.data_byte;
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
			dgst_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// monitor: check digest transfers, then feed accepted items to the predictor
	always @(posedge clk) begin
		dgst_word_t want;
		msg_item_t  it;
		msg_took <= msg_ch.valid && msg_ch.ready;
		if (arst_n) begin
			if (dgst_ch.valid && dgst_ch.ready) begin
				if (digest_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected digest transfer: expected none, got %0d %h %b %b",
						$time, dgst_ch.word_index, dgst_ch.digest_word, dgst_ch.last_word,
						dgst_ch.too_long);
				end else begin
					want = digest_q.pop_front();
					check_field("word_index", 32'(want.word_index), 32'(dgst_ch.word_index));
					check_field("digest_word", want.digest_word, dgst_ch.digest_word);
					check_field("last_word", 32'(want.last_word), 32'(dgst_ch.last_word));
					check_field("too_long", 32'(want.too_long), 32'(dgst_ch.too_long));
				end
			end
			if (msg_ch.valid && msg_ch.ready) begin
				it.cmd       = msg_ch.cmd;
				it.data_byte = msg_ch.data_byte;
				absorb_item(it);
			end
		end
	end

	initial begin
		int budget;
		int len;
		errors    = 0;
		gap_pct   = 0;
		stall_pct = 0;
		msg_took  = 1'b0;
		clear_msg_state();
		@(posedge arst_n);

		// empty messages back to back, "abc", single extreme bytes
		queue_finish(8'h00);
		queue_finish(8'hFF);
		queue_byte(8'h61);
		queue_byte(8'h62);
		queue_byte(8'h63);
		queue_finish(8'h5A);
		queue_byte(8'h00);
		queue_finish(8'hA5);
		queue_byte(8'hFF);
		queue_finish(8'h00);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 72; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 72; end
				default: begin gap_pct = 17; stall_pct = 17; end
			endcase
			budget = 0;
			while (budget < 72) begin
				len = pick_length();
				queue_random_message(len);
				budget += len + 1;
			end
			while (msg_q.size() != 0 || msg_ch.valid || digest_q.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule

[sha1_hash_engine.f]
hdl/sha1_pkg.sv
hdl/sha1_if.sv
hdl/sha1_dp.sv
hdl/sha1_ctrl.sv
hdl/sha1_hash_engine.sv
tb/sha1_hash_engine_tb.sv
